@@ src/ssg_pkg.sv @@
// Shared types, constants and lookup functions for the seven-segment glyph
// vertex generator. No dependencies; imported by ssg_geom and the top level.
package ssg_pkg;

    localparam int CFG_W  = 10;
    localparam int MASK_W = 10;
    localparam int SUM_W  = 16;     // exact width of origin plus offset

    typedef logic [CFG_W-1:0]  cfg_word_t;
    typedef logic [MASK_W-1:0] seg_mask_t;
    typedef logic [3:0]        seg_t;
    typedef logic [2:0]        vtx_t;
    typedef logic [7:0]        border_t;
    typedef logic signed [11:0] coff_t;   // vertex offset from the cell origin

    // register indexes on the config port
    localparam logic [0:0] REG_CELL_WIDTH  = 1'b0;
    localparam logic [0:0] REG_CELL_HEIGHT = 1'b1;

    localparam cfg_word_t WIDTH_RESET  = 10'd20;
    localparam cfg_word_t HEIGHT_RESET = 10'd30;

    // x / 5 == (x * 205) >> 10 for every 10-bit x
    localparam int unsigned DIV5_MUL   = 205;
    localparam int unsigned DIV5_SHIFT = 10;

    localparam seg_t SEG_MIDDLE = 4'd6;
    localparam vtx_t VTX_LAST_QUAD = 3'd3;
    localparam vtx_t VTX_LAST_HEX  = 3'd5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam seg_mask_t MASK_COLON = 10'h300;
    localparam seg_mask_t MASK_DOT   = 10'h080;
    localparam seg_mask_t MASK_MINUS = 10'h040;
    localparam seg_mask_t MASK_NONE  = 10'h000;

    localparam seg_mask_t DIGIT_MASK [10] = '{
        10'h03F, 10'h006, 10'h05B, 10'h04F, 10'h066,
        10'h06D, 10'h07D, 10'h007, 10'h07F, 10'h06F
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TERM,
        ST_FINE,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        GP_HOLD,
        GP_DIV,
        GP_TERM,
        GP_FINE
    } geom_phase_t;

    // precomputed geometry terms a vertex offset is picked from
    typedef enum logic [4:0] {
        T_ZERO, T_W, T_H, T_WB, T_HB, T_BIG, T_WMWB, T_HH, T_HMH, T_HPH,
        T_HMHB, T_HBIG, T_CX, T_CXS, T_CY8, T_CY8S, T_CY9, T_CY9S
    } term_t;

    typedef enum logic [1:0] {
        ADJ_M1,
        ADJ_Z,
        ADJ_P1
    } adj_t;

    typedef struct packed {
        term_t tx;
        adj_t  ax;
        term_t ty;
        adj_t  ay;
    } vplan_t;

    typedef struct packed {
        coff_t w;
        coff_t h;
        coff_t wb;
        coff_t hb;
        coff_t big;
        coff_t small_side;
        coff_t hh;
        coff_t hmh;
        coff_t hph;
        coff_t wmwb;
        coff_t hmhb;
        coff_t hbig;
        coff_t cx;
        coff_t cxs;
        coff_t cy8;
        coff_t cy8s;
        coff_t cy9;
        coff_t cy9s;
    } terms_t;

    function automatic seg_mask_t char_to_mask(input logic [7:0] c);
        logic [7:0] d;
        seg_mask_t  m;
        begin
            d = c - CHAR_ZERO;
            m = MASK_NONE;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                m = DIGIT_MASK[d[3:0]];
            else if (c == CHAR_COLON)
                m = MASK_COLON;
            else if (c == CHAR_DOT)
                m = MASK_DOT;
            else if (c == CHAR_MINUS)
                m = MASK_MINUS;
            return m;
        end
    endfunction

    // index of the lowest lit segment
    function automatic seg_t lowest_seg(input seg_mask_t m);
        seg_t s;
        begin
            s = '0;
            for (int i = MASK_W - 1; i >= 0; i--)
                if (m[i])
                    s = seg_t'(i);
            return s;
        end
    endfunction

    function automatic vplan_t mk(input term_t tx, input adj_t ax,
                                  input term_t ty, input adj_t ay);
        vplan_t p;
        begin
            p.tx = tx;
            p.ax = ax;
            p.ty = ty;
            p.ay = ay;
            return p;
        end
    endfunction

    // x term, x adjust, y term, y adjust for vertex k of segment s
    function automatic vplan_t vertex_plan(input seg_t s, input vtx_t k);
        vplan_t p;
        begin
            p = mk(T_ZERO, ADJ_Z, T_ZERO, ADJ_Z);
            unique case (s)
                4'd0: unique case (k)
                    3'd0:    p = mk(T_ZERO, ADJ_P1, T_ZERO, ADJ_Z);
                    3'd1:    p = mk(T_W,    ADJ_M1, T_ZERO, ADJ_Z);
                    3'd2:    p = mk(T_WMWB, ADJ_M1, T_HB,   ADJ_Z);
                    default: p = mk(T_WB,   ADJ_P1, T_HB,   ADJ_Z);
                endcase
                4'd1: unique case (k)
                    3'd0:    p = mk(T_W,    ADJ_Z, T_ZERO, ADJ_P1);
                    3'd1:    p = mk(T_W,    ADJ_Z, T_HH,   ADJ_M1);
                    3'd2:    p = mk(T_WMWB, ADJ_Z, T_HMH,  ADJ_M1);
                    default: p = mk(T_WMWB, ADJ_Z, T_HB,   ADJ_P1);
                endcase
                4'd2: unique case (k)
                    3'd0:    p = mk(T_W,    ADJ_Z, T_HH,   ADJ_P1);
                    3'd1:    p = mk(T_W,    ADJ_Z, T_H,    ADJ_M1);
                    3'd2:    p = mk(T_WMWB, ADJ_Z, T_HMHB, ADJ_M1);
                    default: p = mk(T_WMWB, ADJ_Z, T_HPH,  ADJ_P1);
                endcase
                4'd3: unique case (k)
                    3'd0:    p = mk(T_ZERO, ADJ_P1, T_H,    ADJ_Z);
                    3'd1:    p = mk(T_WB,   ADJ_P1, T_HMHB, ADJ_Z);
                    3'd2:    p = mk(T_WMWB, ADJ_M1, T_HMHB, ADJ_Z);
                    default: p = mk(T_W,    ADJ_M1, T_H,    ADJ_Z);
                endcase
                4'd4: unique case (k)
                    3'd0:    p = mk(T_ZERO, ADJ_Z, T_HH,   ADJ_P1);
                    3'd1:    p = mk(T_ZERO, ADJ_Z, T_H,    ADJ_M1);
                    3'd2:    p = mk(T_WB,   ADJ_Z, T_HMHB, ADJ_M1);
                    default: p = mk(T_WB,   ADJ_Z, T_HPH,  ADJ_P1);
                endcase
                4'd5: unique case (k)
                    3'd0:    p = mk(T_ZERO, ADJ_Z, T_ZERO, ADJ_P1);
                    3'd1:    p = mk(T_ZERO, ADJ_Z, T_HH,   ADJ_M1);
                    3'd2:    p = mk(T_WB,   ADJ_Z, T_HMH,  ADJ_M1);
                    default: p = mk(T_WB,   ADJ_Z, T_HB,   ADJ_P1);
                endcase
                4'd6: unique case (k)
                    3'd0:    p = mk(T_WB,   ADJ_P1, T_HMH, ADJ_Z);
                    3'd1:    p = mk(T_WMWB, ADJ_M1, T_HMH, ADJ_Z);
                    3'd2:    p = mk(T_W,    ADJ_M1, T_HH,  ADJ_Z);
                    3'd3:    p = mk(T_WMWB, ADJ_M1, T_HPH, ADJ_Z);
                    3'd4:    p = mk(T_WB,   ADJ_P1, T_HPH, ADJ_Z);
                    default: p = mk(T_ZERO, ADJ_P1, T_HH,  ADJ_Z);
                endcase
                4'd7: unique case (k)
                    3'd0:    p = mk(T_ZERO, ADJ_Z, T_HBIG, ADJ_Z);
                    3'd1:    p = mk(T_BIG,  ADJ_Z, T_HBIG, ADJ_Z);
                    3'd2:    p = mk(T_BIG,  ADJ_Z, T_H,    ADJ_Z);
                    default: p = mk(T_ZERO, ADJ_Z, T_H,    ADJ_Z);
                endcase
                4'd8: unique case (k)
                    3'd0:    p = mk(T_CX,  ADJ_Z, T_CY8,  ADJ_Z);
                    3'd1:    p = mk(T_CXS, ADJ_Z, T_CY8,  ADJ_Z);
                    3'd2:    p = mk(T_CXS, ADJ_Z, T_CY8S, ADJ_Z);
                    default: p = mk(T_CX,  ADJ_Z, T_CY8S, ADJ_Z);
                endcase
                default: unique case (k)
                    3'd0:    p = mk(T_CX,  ADJ_Z, T_CY9,  ADJ_Z);
                    3'd1:    p = mk(T_CXS, ADJ_Z, T_CY9,  ADJ_Z);
                    3'd2:    p = mk(T_CXS, ADJ_Z, T_CY9S, ADJ_Z);
                    default: p = mk(T_CX,  ADJ_Z, T_CY9S, ADJ_Z);
                endcase
            endcase
            return p;
        end
    endfunction

endpackage

@@ src/ssg_geom.sv @@
// Geometry unit: derives the cell borders and the shared offset terms over
// three setup phases, then serves one vertex offset pair per cycle. Uses ssg_pkg.
module ssg_geom
(
    input  logic                clk,
    input  ssg_pkg::geom_phase_t phase,
    input  ssg_pkg::cfg_word_t  cell_width,
    input  ssg_pkg::cfg_word_t  cell_height,
    input  ssg_pkg::seg_t       seg,
    input  ssg_pkg::vtx_t       vtx,
    output ssg_pkg::coff_t      offset_x,
    output ssg_pkg::coff_t      offset_y
);
    import ssg_pkg::*;

    terms_t  terms_reg;
    terms_t  terms_next;
    vplan_t  plan;
    logic [CFG_W+7:0] prod_w;
    logic [CFG_W+7:0] prod_h;
    coff_t   cx_tmp;
    coff_t   cy_q;

    function automatic coff_t pick(input terms_t t, input term_t sel);
        coff_t v;
        begin
            unique case (sel)
                T_ZERO:  v = '0;
                T_W:     v = t.w;
                T_H:     v = t.h;
                T_WB:    v = t.wb;
                T_HB:    v = t.hb;
                T_BIG:   v = t.big;
                T_WMWB:  v = t.wmwb;
                T_HH:    v = t.hh;
                T_HMH:   v = t.hmh;
                T_HPH:   v = t.hph;
                T_HMHB:  v = t.hmhb;
                T_HBIG:  v = t.hbig;
                T_CX:    v = t.cx;
                T_CXS:   v = t.cxs;
                T_CY8:   v = t.cy8;
                T_CY8S:  v = t.cy8s;
                T_CY9:   v = t.cy9;
                T_CY9S:  v = t.cy9s;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic coff_t adj_val(input adj_t a);
        coff_t v;
        begin
            unique case (a)
                ADJ_M1:  v = -12'sd1;
                ADJ_P1:  v = 12'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // setup: divide by five, then first- and second-order terms
    always_comb
    begin
        terms_next = terms_reg;
        prod_w = {8'd0, cell_width}  * (CFG_W+8)'(DIV5_MUL);
        prod_h = {8'd0, cell_height} * (CFG_W+8)'(DIV5_MUL);
        cx_tmp = (terms_reg.w - terms_reg.small_side) >>> 1;
        cy_q   = terms_reg.h >>> 2;
        unique case (phase)
            GP_DIV:
            begin
                terms_next.w  = $signed({2'b00, cell_width});
                terms_next.h  = $signed({2'b00, cell_height});
                terms_next.wb = $signed({4'b0000, border_t'(prod_w >> DIV5_SHIFT)});
                terms_next.hb = $signed({4'b0000, border_t'(prod_h >> DIV5_SHIFT)});
            end
            GP_TERM:
            begin
                terms_next.big = (terms_reg.wb > terms_reg.hb) ? terms_reg.wb : terms_reg.hb;
                terms_next.small_side =
                    (terms_reg.wb < terms_reg.hb) ? terms_reg.wb : terms_reg.hb;
                terms_next.hh   = terms_reg.h >>> 1;
                terms_next.hmh  = (terms_reg.h - terms_reg.hb) >>> 1;
                terms_next.hph  = (terms_reg.h + terms_reg.hb) >>> 1;
                terms_next.wmwb = terms_reg.w - terms_reg.wb;
                terms_next.hmhb = terms_reg.h - terms_reg.hb;
                terms_next.cy8  = cy_q;
                terms_next.cy9  = cy_q + (cy_q <<< 1);
            end
            GP_FINE:
            begin
                terms_next.hbig = terms_reg.h - terms_reg.big;
                terms_next.cx   = cx_tmp;
                terms_next.cxs  = cx_tmp + terms_reg.small_side;
                terms_next.cy8s = terms_reg.cy8 + terms_reg.small_side;
                terms_next.cy9s = terms_reg.cy9 + terms_reg.small_side;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        terms_reg <= terms_next;
    end

    always_comb
    begin
        plan     = vertex_plan(seg, vtx);
        offset_x = pick(terms_reg, plan.tx) + adj_val(plan.ax);
        offset_y = pick(terms_reg, plan.ty) + adj_val(plan.ay);
    end

endmodule

@@ src/seven_segment_glyph_vertex_gen_core.sv @@
// Seven-segment glyph vertex generator, top level: stream ports, config
// registers, segment sequencer and output register. Uses ssg_pkg, ssg_geom.
//
// Usage
//   Input items arrive on s_axis: a character byte and the cell origin.
//   Each lit segment of the glyph is sent on m_axis as a polygon, one
//   vertex per item, segments in ascending order. tuser carries the
//   segment index and a polygon-end flag; tlast marks the character's
//   final vertex. Unknown characters produce no output items at all.
//   cell_width / cell_height are set through cfg_we/cfg_index/cfg_data
//   and should only be written while the block is idle.
// Timing
//   s_axis_tready is high only in the idle state. After an item is taken,
//   the geometry unit derives borders and offset terms in its setup phases
//   (div, term, fine) before the first vertex is loaded on m_axis.
//   Then one vertex per cycle unless m_axis_tready stalls, and the next
//   item is accepted the cycle after the last vertex is loaded.
//   The per-vertex adder/selector of the geometry unit sets the rate.
// Reset / stall
//   Reset returns to idle, drops m_axis_tvalid and restores the cell size
//   to 20 x 30. A stalled m_axis_tready freezes the sequencer; the held
//   vertex stays on the port until taken.
module seven_segment_glyph_vertex_gen_core
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // config write port
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  ssg_pkg::cfg_word_t  cfg_data,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // char_code[7:0], origin_x[22:8], origin_y[37:23]
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // vertex_index[2:0], vertex_x[18:3], vertex_y[34:19]
    output logic [4:0]          m_axis_tuser,   // segment_index[3:0], polygon_last[4]
    output logic                m_axis_tlast    // char_last
);
    import ssg_pkg::*;

    state_t     state_reg, state_next;
    cfg_word_t  cell_width_reg, cell_width_next;
    cfg_word_t  cell_height_reg, cell_height_next;
    seg_mask_t  rem_mask_reg, rem_mask_next;
    vtx_t       vtx_reg, vtx_next;
    logic signed [14:0] ox_reg, ox_next;
    logic signed [14:0] oy_reg, oy_next;

    logic       out_valid_reg, out_valid_next;
    seg_t       out_seg_reg, out_seg_next;
    vtx_t       out_vtx_reg, out_vtx_next;
    logic [15:0] out_x_reg, out_x_next;
    logic [15:0] out_y_reg, out_y_next;
    logic       out_plast_reg, out_plast_next;
    logic       out_clast_reg, out_clast_next;

    geom_phase_t phase;
    seg_t       seg_cur;
    vtx_t       last_vtx;
    logic       poly_last;
    seg_mask_t  rem_after;
    logic       char_end;
    logic       advance;
    logic       in_accept;
    seg_mask_t  in_mask;
    coff_t      offset_x, offset_y;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic [15:0] wrap_x, wrap_y;

    ssg_geom u_geom
    (
        .clk         (clk),
        .phase       (phase),
        .cell_width  (cell_width_reg),
        .cell_height (cell_height_reg),
        .seg         (seg_cur),
        .vtx         (vtx_reg),
        .offset_x    (offset_x),
        .offset_y    (offset_y)
    );

    // exact sum; the origin is 15 bits and offsets stay within 12
    assign sum_x = SUM_W'(ox_reg) + SUM_W'(offset_x);
    assign sum_y = SUM_W'(oy_reg) + SUM_W'(offset_y);

    // wrap to COORD_BITS, sign extend into the 16-bit field
    generate
        if (COORD_BITS >= 16)
        begin : g_wide
            assign wrap_x = sum_x[15:0];
            assign wrap_y = sum_y[15:0];
        end
        else
        begin : g_narrow
            assign wrap_x = {{(16-COORD_BITS){sum_x[COORD_BITS-1]}}, sum_x[COORD_BITS-1:0]};
            assign wrap_y = {{(16-COORD_BITS){sum_y[COORD_BITS-1]}}, sum_y[COORD_BITS-1:0]};
        end
    endgenerate

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_mask       = char_to_mask(s_axis_tdata[7:0]);

    always_comb
    begin
        state_next       = state_reg;
        cell_width_next  = cell_width_reg;
        cell_height_next = cell_height_reg;
        rem_mask_next    = rem_mask_reg;
        vtx_next         = vtx_reg;
        ox_next          = ox_reg;
        oy_next          = oy_reg;
        out_valid_next   = out_valid_reg;
        out_seg_next     = out_seg_reg;
        out_vtx_next     = out_vtx_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_plast_next   = out_plast_reg;
        out_clast_next   = out_clast_reg;
        phase            = GP_HOLD;

        seg_cur   = lowest_seg(rem_mask_reg);
        last_vtx  = (seg_cur == SEG_MIDDLE) ? VTX_LAST_HEX : VTX_LAST_QUAD;
        poly_last = (vtx_reg == last_vtx);
        rem_after = rem_mask_reg & ~(seg_mask_t'(1) << seg_cur);
        char_end  = poly_last && (rem_after == MASK_NONE);
        advance   = (state_reg == ST_RUN) && (!out_valid_reg || m_axis_tready);

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_WIDTH:  cell_width_next  = cfg_data;
                REG_CELL_HEIGHT: cell_height_next = cfg_data;
                default: ;
            endcase
        end

        if (m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_mask != MASK_NONE)
                begin
                    rem_mask_next = in_mask;
                    vtx_next      = '0;
                    ox_next       = $signed(s_axis_tdata[22:8]);
                    oy_next       = $signed(s_axis_tdata[37:23]);
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                phase      = GP_DIV;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                phase      = GP_TERM;
                state_next = ST_FINE;
            end
            ST_FINE:
            begin
                phase      = GP_FINE;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_seg_next   = seg_cur;
                    out_vtx_next   = vtx_reg;
                    out_x_next     = wrap_x;
                    out_y_next     = wrap_y;
                    out_plast_next = poly_last;
                    out_clast_next = char_end;
                    if (poly_last)
                    begin
                        rem_mask_next = rem_after;
                        vtx_next      = '0;
                    end
                    else
                        vtx_next = vtx_reg + vtx_t'(1);
                    if (char_end)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cell_width_reg  <= WIDTH_RESET;
            cell_height_reg <= HEIGHT_RESET;
            rem_mask_reg    <= MASK_NONE;
            vtx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cell_width_reg  <= cell_width_next;
            cell_height_reg <= cell_height_next;
            rem_mask_reg    <= rem_mask_next;
            vtx_reg         <= vtx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        out_seg_reg   <= out_seg_next;
        out_vtx_reg   <= out_vtx_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_plast_reg <= out_plast_next;
        out_clast_reg <= out_clast_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_y_reg, out_x_reg, out_vtx_reg};
    assign m_axis_tuser  = {out_plast_reg, out_seg_reg};
    assign m_axis_tlast  = out_clast_reg;

    // the sequencer never runs with nothing left to draw
    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> rem_mask_reg != MASK_NONE)
        else $error("run state with empty segment mask");

    // a character ends on a polygon boundary
    a_char_end_poly: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_clast_reg |-> out_plast_reg)
        else $error("char_last without polygon_last");

    // only the middle bar has vertices past index 3
    a_hex_only_middle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_vtx_reg > VTX_LAST_QUAD |-> out_seg_reg == SEG_MIDDLE)
        else $error("vertex index too large for segment");

    // a held vertex is not overwritten while stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_x_reg)
            && $stable(out_y_reg) && $stable(out_seg_reg))
        else $error("stalled vertex changed");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for seven_segment_glyph_vertex_gen_core: directed and random glyphs,
// with a built-in vertex predictor and random stalls on both streams.
// Depends on ssg_pkg (register indexes, config word type) and the core itself.
module tb_top;

    import ssg_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;  // hard stop for a hung run
    localparam int QUIET_LIMIT = 2000;     // cycles with no handshake before giving up a drain
    localparam int LONG_STALL  = 400;      // receiver hold-off, well past one glyph
    localparam int TAIL_CYCLES = 20;       // idle wait after a drain; leave margin

    localparam logic [14:0] ORG_MIN = 15'h4000;   // -16384
    localparam logic [14:0] ORG_MAX = 15'h3FFF;   //  16383

    localparam logic [7:0] GLYPH_COLON = 8'h3A;
    localparam logic [7:0] GLYPH_DOT   = 8'h2E;
    localparam logic [7:0] GLYPH_MINUS = 8'h2D;

    // segment numbers with special shapes
    localparam int SEG_MID  = 6;
    localparam int SEG_DOT  = 7;
    localparam int SEG_COL0 = 8;

    typedef struct packed {
        logic [3:0]  seg;
        logic [2:0]  vtx;
        logic [15:0] x;
        logic [15:0] y;
        logic        poly_end;
        logic        char_end;
    } vertex_t;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    cfg_word_t   cfg_data = '0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // char_code[7:0], origin_x[22:8], origin_y[37:23]

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // vertex_index[2:0], vertex_x[18:3], vertex_y[34:19]
    logic [4:0]  m_axis_tuser;        // segment_index[3:0], polygon_last[4]
    logic        m_axis_tlast;        // char_last

    always #5 clk = ~clk;

    seven_segment_glyph_vertex_gen_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------
    logic [39:0] glyph_q[$];     // input items not yet handed to the driver
    vertex_t     vertex_q[$];    // vertices the block still owes us

    int cell_w = 20;             // predictor copy of the size registers
    int cell_h = 30;

    int in_gap_max  = 15;        // per-phase idle ranges, set by the sequence below
    int out_gap_max = 15;
    int stall_at    = -1;        // vertex count after which the receiver holds off

    int errors   = 0;
    int rx_total = 0;
    int cycles   = 0;

    logic in_fire  = 1'b0;       // handshakes seen at the last rising edge
    logic out_fire = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [9:0] lit_segments(input logic [7:0] c);
        logic [9:0] m;
        begin
            case (c)
                "0":         m = 10'h03F;
                "1":         m = 10'h006;
                "2":         m = 10'h05B;
                "3":         m = 10'h04F;
                "4":         m = 10'h066;
                "5":         m = 10'h06D;
                "6":         m = 10'h07D;
                "7":         m = 10'h007;
                "8":         m = 10'h07F;
                "9":         m = 10'h06F;
                GLYPH_COLON: m = 10'h300;
                GLYPH_DOT:   m = 10'h080;
                GLYPH_MINUS: m = 10'h040;
                default:     m = 10'h000;
            endcase
            return m;
        end
    endfunction

    // offset of vertex k of segment s from the cell origin, at the current cell size
    function automatic void vertex_offset(input int s, input int k,
                                          output int dx, output int dy);
        int w, h, wb, hb, big, sml, cx, cy;
        int xs[6];
        int ys[6];
        begin
            w   = cell_w;
            h   = cell_h;
            wb  = w / 5;
            hb  = h / 5;
            big = (wb > hb) ? wb : hb;
            sml = (wb < hb) ? wb : hb;
            for (int i = 0; i < 6; i++)
            begin
                xs[i] = 0;
                ys[i] = 0;
            end
            case (s)
                0:
                begin   // top bar
                    xs[0] = 1;          ys[0] = 0;
                    xs[1] = w - 1;      ys[1] = 0;
                    xs[2] = w - wb - 1; ys[2] = hb;
                    xs[3] = wb + 1;     ys[3] = hb;
                end
                1:
                begin   // upper right
                    xs[0] = w;      ys[0] = 1;
                    xs[1] = w;      ys[1] = (h >>> 1) - 1;
                    xs[2] = w - wb; ys[2] = ((h - hb) >>> 1) - 1;
                    xs[3] = w - wb; ys[3] = hb + 1;
                end
                2:
                begin   // lower right
                    xs[0] = w;      ys[0] = (h >>> 1) + 1;
                    xs[1] = w;      ys[1] = h - 1;
                    xs[2] = w - wb; ys[2] = h - hb - 1;
                    xs[3] = w - wb; ys[3] = ((h + hb) >>> 1) + 1;
                end
                3:
                begin   // bottom bar
                    xs[0] = 1;          ys[0] = h;
                    xs[1] = wb + 1;     ys[1] = h - hb;
                    xs[2] = w - wb - 1; ys[2] = h - hb;
                    xs[3] = w - 1;      ys[3] = h;
                end
                4:
                begin   // lower left
                    xs[0] = 0;  ys[0] = (h >>> 1) + 1;
                    xs[1] = 0;  ys[1] = h - 1;
                    xs[2] = wb; ys[2] = h - hb - 1;
                    xs[3] = wb; ys[3] = ((h + hb) >>> 1) + 1;
                end
                5:
                begin   // upper left
                    xs[0] = 0;  ys[0] = 1;
                    xs[1] = 0;  ys[1] = (h >>> 1) - 1;
                    xs[2] = wb; ys[2] = ((h - hb) >>> 1) - 1;
                    xs[3] = wb; ys[3] = hb + 1;
                end
                SEG_MID:
                begin   // hexagonal middle bar
                    xs[0] = wb + 1;     ys[0] = (h - hb) >>> 1;
                    xs[1] = w - wb - 1; ys[1] = (h - hb) >>> 1;
                    xs[2] = w - 1;      ys[2] = h >>> 1;
                    xs[3] = w - wb - 1; ys[3] = (h + hb) >>> 1;
                    xs[4] = wb + 1;     ys[4] = (h + hb) >>> 1;
                    xs[5] = 1;          ys[5] = h >>> 1;
                end
                SEG_DOT:
                begin   // dot: square of the larger border, bottom left
                    xs[0] = 0;   ys[0] = h - big;
                    xs[1] = big; ys[1] = h - big;
                    xs[2] = big; ys[2] = h;
                    xs[3] = 0;   ys[3] = h;
                end
                default:
                begin   // colon squares, side is the smaller border
                    cx = (w - sml) >>> 1;
                    cy = (s == SEG_COL0) ? (h >>> 2) : (h >>> 2) * 3;
                    xs[0] = cx;       ys[0] = cy;
                    xs[1] = cx + sml; ys[1] = cy;
                    xs[2] = cx + sml; ys[2] = cy + sml;
                    xs[3] = cx;       ys[3] = cy + sml;
                end
            endcase
            dx = xs[k];
            dy = ys[k];
        end
    endfunction

    // queue every vertex the accepted glyph item should produce
    task automatic queue_glyph(input logic [39:0] word);
        logic [9:0] lit;
        int         ox, oy, dx, dy, cnt, top, sx, sy;
        vertex_t    v;
        begin
            lit = lit_segments(word[7:0]);
            ox  = int'($signed(word[22:8]));
            oy  = int'($signed(word[37:23]));
            top = -1;
            for (int s = 0; s < 10; s++)
                if (lit[s])
                    top = s;
            for (int s = 0; s < 10; s++)
            begin
                if (lit[s])
                begin
                    cnt = (s == SEG_MID) ? 6 : 4;
                    for (int k = 0; k < cnt; k++)
                    begin
                        vertex_offset(s, k, dx, dy);
                        sx = ox + dx;
                        sy = oy + dy;
                        v.seg      = s[3:0];
                        v.vtx      = k[2:0];
                        v.x        = sx[15:0];   // 16-bit two's complement wrap
                        v.y        = sy[15:0];
                        v.poly_end = (k == cnt - 1);
                        v.char_end = (k == cnt - 1) && (s == top);
                        vertex_q.push_back(v);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sampling at the rising edge: predict on input handshakes, check outputs
    // ------------------------------------------------------------------
    vertex_t got, want;

    always @(posedge clk)
    begin
        in_fire  <= rst_n && s_axis_tvalid && s_axis_tready;
        out_fire <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            queue_glyph(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.seg      = m_axis_tuser[3:0];
            got.poly_end = m_axis_tuser[4];
            got.vtx      = m_axis_tdata[2:0];
            got.x        = m_axis_tdata[18:3];
            got.y        = m_axis_tdata[34:19];
            got.char_end = m_axis_tlast;
            if (vertex_q.size() == 0)
            begin
                $display("%0t ERROR unexpected vertex: seg %0d vtx %0d x %0d y %0d",
                         $time, got.seg, got.vtx, $signed(got.x), $signed(got.y),
                         " poly %b char %b", got.poly_end, got.char_end);
                errors++;
            end
            else
            begin
                want = vertex_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t ERROR vertex mismatch: expected seg %0d vtx %0d x %0d y %0d",
                             $time, want.seg, want.vtx, $signed(want.x), $signed(want.y),
                             " poly %b char %b", want.poly_end, want.char_end);
                    $display("%0t                          actual seg %0d vtx %0d x %0d y %0d",
                             $time, got.seg, got.vtx, $signed(got.x), $signed(got.y),
                             " poly %b char %b", got.poly_end, got.char_end);
                    errors++;
                end
            end
            rx_total++;
        end
    end

    // ------------------------------------------------------------------
    // input driver, falling edge: random gap before each item, then hold
    // tvalid until the item is taken
    // ------------------------------------------------------------------
    logic [39:0] cur_item;
    logic        have_cur = 1'b0;
    logic        offering;
    int          in_wait = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            offering = s_axis_tvalid && !in_fire;
            if (!offering)
            begin
                if (!have_cur && glyph_q.size() != 0)
                begin
                    cur_item = glyph_q.pop_front();
                    have_cur = 1'b1;
                    in_wait  = $urandom_range(0, in_gap_max);
                end
                if (have_cur)
                begin
                    if (in_wait == 0)
                    begin
                        offering = 1'b1;
                        have_cur = 1'b0;
                        s_axis_tdata <= cur_item;
                    end
                    else
                        in_wait--;
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // output receiver, falling edge: random wait after each vertex, plus one
    // long hold-off so the core backs up and drops s_axis_tready
    // ------------------------------------------------------------------
    int out_wait   = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (out_fire)
            begin
                out_wait = $urandom_range(0, out_gap_max);
                if (rx_total == stall_at)
                    stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                out_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic offer(input logic [7:0] c, input logic [14:0] ox, input logic [14:0] oy);
        glyph_q.push_back({2'b00, oy, ox, c});
    endtask

    // config writes happen only with the core idle, so the predictor copy
    // can be updated right away
    task automatic write_reg(input logic [0:0] idx, input int value);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value[9:0];
            if (idx == REG_CELL_WIDTH)
                cell_w = value & 32'h3FF;
            else
                cell_h = value & 32'h3FF;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic set_cell(input int w, input int h);
        begin
            write_reg(REG_CELL_WIDTH, w);
            write_reg(REG_CELL_HEIGHT, h);
        end
    endtask

    // sender pauses until every queued item is in and every vertex is out;
    // a drain that makes no progress for too long is reported and dropped
    task automatic settle();
        int quiet;
        begin
            quiet = 0;
            while ((glyph_q.size() != 0 || have_cur || s_axis_tvalid || vertex_q.size() != 0)
                   && quiet < QUIET_LIMIT)
            begin
                @(posedge clk);
                if (in_fire || out_fire)
                    quiet = 0;
                else
                    quiet++;
            end
            if (vertex_q.size() != 0)
            begin
                $display("%0t ERROR %0d expected vertices never arrived",
                         $time, vertex_q.size());
                errors++;
                vertex_q.delete();
            end
            // idle margin before the next config write
            repeat (TAIL_CYCLES) @(posedge clk);
        end
    endtask

    function automatic logic [14:0] corner(input int i);
        logic [14:0] v;
        begin
            case (i % 4)
                0:       v = 15'h0000;
                1:       v = ORG_MIN;
                2:       v = ORG_MAX;
                default: v = 15'h2A55;
            endcase
            return v;
        end
    endfunction

    function automatic logic [14:0] draw_origin();
        logic [14:0] v;
        begin
            case ($urandom_range(0, 9))
                0:       v = ORG_MIN;
                1:       v = ORG_MAX;
                default: v = 15'($urandom);
            endcase
            return v;
        end
    endfunction

    // mostly renderable glyphs, the rest any byte at all
    function automatic logic [7:0] draw_char();
        int r;
        logic [7:0] c;
        begin
            r = $urandom_range(0, 15);
            if (r < 10)
                c = 8'("0" + r);
            else if (r == 10)
                c = GLYPH_COLON;
            else if (r == 11)
                c = GLYPH_DOT;
            else if (r == 12)
                c = GLYPH_MINUS;
            else
                c = 8'($urandom_range(0, 255));
            return c;
        end
    endfunction

    function automatic int draw_size();
        int v;
        begin
            case ($urandom_range(0, 3))
                0:       v = $urandom_range(0, 9);        // tiny cells, borders of 0 or 1
                1:       v = $urandom_range(1014, 1023);
                default: v = $urandom_range(0, 1023);
            endcase
            return v;
        end
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    int in_modes[6]  = '{0, 15, 0, 15, 15, 0};
    int out_modes[6] = '{0, 15, 15, 0, 15, 0};

    initial
    begin
        int         known;
        logic [7:0] c;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset cell size 20 x 30: every glyph, two unknown codes, origin corners
        for (int i = 0; i < 10; i++)
            offer(8'("0" + i), corner(i), corner(i + 1));
        offer(GLYPH_COLON, corner(1), corner(2));
        offer(GLYPH_DOT, corner(2), corner(1));
        offer(GLYPH_MINUS, corner(3), corner(0));
        offer(8'hFF, ORG_MAX, ORG_MAX);     // unknown: no vertices
        offer("A", 15'h0000, 15'h0000);
        settle();

        // largest cell; origins at the extremes push the sums past the 15-bit origin range
        set_cell(1023, 1023);
        offer("8", ORG_MAX, ORG_MAX);
        offer("8", ORG_MIN, ORG_MIN);
        offer(GLYPH_COLON, ORG_MAX, ORG_MIN);
        offer(GLYPH_DOT, ORG_MIN, ORG_MAX);
        settle();

        // zero-sized cell: borders vanish and width-1 goes negative
        set_cell(0, 0);
        offer("8", ORG_MIN, ORG_MIN);
        offer(GLYPH_COLON, 15'h0000, 15'h0000);
        offer(GLYPH_DOT, ORG_MAX, ORG_MIN);
        settle();

        // lopsided cells swap which border the dot and colon use
        set_cell(1023, 5);
        offer(GLYPH_DOT, 15'h0000, 15'h0000);
        offer(GLYPH_COLON, 15'h0000, 15'h0000);
        settle();
        set_cell(5, 1023);
        offer(GLYPH_DOT, 15'h0000, 15'h0000);
        offer(GLYPH_COLON, 15'h0000, 15'h0000);
        settle();

        // random phases, each with its own cell size and idle pattern
        for (int ph = 0; ph < 6; ph++)
        begin
            set_cell(draw_size(), draw_size());
            in_gap_max  = in_modes[ph];
            out_gap_max = out_modes[ph];
            if (ph == 1)
                stall_at = rx_total + 20;
            known = 0;
            while (known < 38)
            begin
                c = draw_char();
                if (lit_segments(c) != 10'h000)
                    known++;
                offer(c, draw_origin(), draw_origin());
            end
            settle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/ssg_pkg.sv
src/ssg_geom.sv
src/seven_segment_glyph_vertex_gen_core.sv
tb/sv/tb_top.sv
